### rtl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Types and codes shared by the keyframe track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COMPONENT = 1'd1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_FIRST   = 2'd1,
    KIND_LAST    = 2'd2,
    KIND_INTERP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] val_x;
    logic [31:0] val_y;
    logic [31:0] val_z;
  } key_t;

  typedef struct packed {
    logic               mode;
    logic        [3:0]  key_index;
    logic        [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [31:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic        [1:0]  sample_kind;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/keyframe_track_interpolator_top.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_top
// Keyframe table with linear search and linear interpolation of three
// Q16.16 components.
// ----------------------------------------------------------------------------
// A write transaction (mode 0) stores one key and gives no result. A sample
// transaction (mode 1) goes from idle straight to ST_EMIT for the empty
// table, through ST_FIRST for the first key, through ST_FIRST and ST_LAST for
// the last key, and on through ST_SCAN when the search runs through all n keys
// without finding a bracketing pair; the search reads one key per cycle from
// the key memory through its single read port. An interpolated result adds
// the FRACTION_BITS + 1 steps of the bit-serial divider, skipped for equal
// bracketing times, and three passes (ST_DIFF, ST_MUL, ST_ACC) through one
// shared multiplier. ST_EMIT loads the output register and raises out_valid,
// and the next transaction is taken from idle. The block takes no new
// transaction while a sample is in work; a finished result waits in the
// output register while the next transaction is taken, and the block holds
// in its last step while an earlier result is still waiting. The key memory
// has no reset: sample only keys that were written. Configuration writes
// complete at once.
`default_nettype none

module keyframe_track_interpolator_top
  import kti_pkg::*;
#(
  parameter int MAX_KEYS      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire in_item_t             in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      out_item_t            out_data,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int DCNT_W = $clog2(FRACTION_BITS + 1);
  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int PROD_W = FRACTION_BITS + 35;

  key_t                     mem [MAX_KEYS];
  key_t                     rd_data;
  logic [IDX_W-1:0]         rd_addr;

  state_t                   state;
  state_t                   state_next;

  logic [4:0]               key_count;
  logic [31:0]              default_comp;

  logic [31:0]              s_time;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         idx;
  key_t                     prev;
  key_t                     cur;
  logic [32:0]              rem;
  logic [31:0]              den;
  logic [FRAC_W-1:0]        frac;
  logic [DCNT_W-1:0]        div_cnt;
  comp_t                    comp;
  logic signed [32:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic [31:0]              res_x;
  logic [31:0]              res_y;
  logic [31:0]              res_z;
  kind_t                    res_kind;

  logic [CNT_W-1:0]         n_sat;
  logic                     sample_acc;
  logic                     write_acc;
  logic                     hit_first;
  logic                     hit_last;
  logic                     bracket;
  logic                     at_end;
  logic                     den_zero;
  logic [32:0]              div_trial;
  logic                     div_bit;
  logic                     emit_load;
  logic [31:0]              a_sel;
  logic [31:0]              b_sel;

  assign cfg_ready  = 1'b1;
  assign sample_acc = in_valid && in_ready && (in_data.mode == MODE_SAMPLE);
  assign write_acc  = in_valid && in_ready && (in_data.mode == MODE_WRITE);
  assign n_sat      = (32'(key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);
  assign hit_first  = (last_idx == '0) || (s_time <= rd_data.key_time);
  assign hit_last   = s_time >= rd_data.key_time;
  assign bracket    = (s_time >= prev.key_time) && (s_time <= rd_data.key_time);
  assign at_end     = idx == last_idx;
  assign den_zero   = rd_data.key_time == prev.key_time;
  assign div_trial  = (div_cnt == DCNT_W'(FRACTION_BITS)) ? rem : {rem[31:0], 1'b0};
  assign div_bit    = div_trial >= {1'b0, den};
  assign emit_load  = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    case (comp)
      COMP_X: begin
        a_sel = prev.val_x;
        b_sel = cur.val_x;
      end
      COMP_Y: begin
        a_sel = prev.val_y;
        b_sel = cur.val_y;
      end
      COMP_Z: begin
        a_sel = prev.val_z;
        b_sel = cur.val_z;
      end
      default: begin
        a_sel = prev.val_x;
        b_sel = cur.val_x;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_acc) begin
          state_next = (n_sat == '0) ? ST_EMIT : ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_next = hit_first ? ST_EMIT : ST_LAST;
      end
      ST_LAST: begin
        state_next = hit_last ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (bracket) begin
          state_next = den_zero ? ST_DIFF : ST_DIV;
        end else if (at_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = (comp == COMP_Z) ? ST_EMIT : ST_DIFF;
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_addr  = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FIRST: begin
        rd_addr = last_idx;
      end
      ST_LAST: begin
        rd_addr = IDX_W'(1);
      end
      ST_SCAN: begin
        rd_addr = idx + IDX_W'(1);
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (write_acc && (32'(in_data.key_index) < MAX_KEYS)) begin
      mem[IDX_W'(in_data.key_index)] <= '{key_time: in_data.key_time,
                                          val_x:    in_data.key_x,
                                          val_y:    in_data.key_y,
                                          val_z:    in_data.key_z};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= '0;
      default_comp <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_COUNT:         key_count    <= cfg_data[4:0];
        REG_DEFAULT_COMPONENT: default_comp <= cfg_data;
        default:               key_count    <= key_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data <= '{result_x:    res_x,
                    result_y:    res_y,
                    result_z:    res_z,
                    sample_kind: res_kind};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_acc) begin
          s_time   <= in_data.sample_time;
          last_idx <= IDX_W'(n_sat - CNT_W'(1));
          res_x    <= default_comp;
          res_y    <= default_comp;
          res_z    <= default_comp;
          res_kind <= KIND_DEFAULT;
        end
      end
      ST_FIRST: begin
        prev     <= rd_data;
        res_x    <= rd_data.val_x;
        res_y    <= rd_data.val_y;
        res_z    <= rd_data.val_z;
        res_kind <= KIND_FIRST;
      end
      ST_LAST: begin
        idx      <= IDX_W'(1);
        res_x    <= rd_data.val_x;
        res_y    <= rd_data.val_y;
        res_z    <= rd_data.val_z;
        res_kind <= KIND_LAST;
      end
      ST_SCAN: begin
        if (bracket) begin
          cur      <= rd_data;
          rem      <= {1'b0, s_time - prev.key_time};
          den      <= rd_data.key_time - prev.key_time;
          frac     <= '0;
          div_cnt  <= DCNT_W'(FRACTION_BITS);
          comp     <= COMP_X;
          res_kind <= KIND_INTERP;
        end else begin
          prev     <= rd_data;
          idx      <= idx + IDX_W'(1);
          res_x    <= rd_data.val_x;
          res_y    <= rd_data.val_y;
          res_z    <= rd_data.val_z;
          res_kind <= KIND_LAST;
        end
      end
      ST_DIV: begin
        rem     <= div_bit ? (div_trial - {1'b0, den}) : div_trial;
        frac    <= {frac[FRAC_W-2:0], div_bit};
        div_cnt <= div_cnt - DCNT_W'(1);
      end
      ST_DIFF: begin
        diff <= $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
      end
      ST_MUL: begin
        prod <= diff * $signed({1'b0, frac});
      end
      ST_ACC: begin
        case (comp)
          COMP_X: begin
            res_x <= a_sel + prod[FRACTION_BITS+31:FRACTION_BITS];
            comp  <= COMP_Y;
          end
          COMP_Y: begin
            res_y <= a_sel + prod[FRACTION_BITS+31:FRACTION_BITS];
            comp  <= COMP_Z;
          end
          default: begin
            res_z <= a_sel + prod[FRACTION_BITS+31:FRACTION_BITS];
            comp  <= COMP_X;
          end
        endcase
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != '0)
    else $error("divider running with zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem <= {1'b0, den})
    else $error("divider remainder out of range");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    sample_acc |=> !in_ready)
    else $error("new transaction taken during a sample");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> out_valid && state == ST_IDLE)
    else $error("result not presented after emit");

endmodule

`default_nettype wire
